// ===== hw/rtl/cbsg_pkg.sv =====
// ----------------------------------------------------------------------------
// cbsg_pkg
// Shared types and constants of the cubic Bezier spline generator: coordinate
// format, the curve job passed from the front end to the back end, sequencer
// states and the fixed-point rounding constants.
// ----------------------------------------------------------------------------
`default_nettype none

package cbsg_pkg;

  // Coordinates are signed Q4.12.
  localparam int CW = 16;
  // Stream data word: x in the low half, y above it, padded to whole bytes.
  localparam int TDATA_W = ((2 * CW + 7) / 8) * 8;

  // Section count register.
  localparam int SC_W = 4;
  localparam logic [SC_W-1:0] SC_RESET = 4'd10;
  localparam int SC_MAX_CODE = (1 << SC_W) - 1;
  localparam int MAX_SECTIONS_DEF = 15;

  // Bezier coefficients need four bits above the coordinate width.
  localparam int COEF_W = CW + 4;

  // Depth of the job queue between front and back.
  localparam int QDEPTH = 2;

  // Rounding: r = floor((num + 500) / 1000), saturated to CW bits.
  localparam longint SAT_SPAN = 1000 * (longint'(1) << (CW - 1));
  localparam longint HI_LIM = SAT_SPAN - 500;
  localparam longint LO_LIM = -(SAT_SPAN + 500);
  localparam longint BIAS = SAT_SPAN + 500;
  // Biased value below 1000 * 2^CW, then split as /8 followed by /125.
  localparam int V_W = CW + 10;
  localparam int DIV_SHIFT = 3;
  localparam int DIV_ODD = 125;
  localparam int U_W = V_W - DIV_SHIFT;
  // floor(2^30 / 125): the estimate is low by at most one.
  localparam int RECIP_W = 24;
  localparam int RECIP = 8589934;
  localparam int RECIP_SH = 30;
  localparam int REM_W = 8;
  // Register stages of the rounding pipeline.
  localparam int RND_LAT = 4;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] dy;
    logic [SC_W-1:0]      sc;
  } job_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_COEF  = 4'b0010,
    ST_PRIME = 4'b0100,
    ST_RUN   = 4'b1000
  } seq_state_t;

  // Accumulator width for curves of up to eff_max sections.
  function automatic int num_width(input int eff_max);
    return COEF_W + 3 * $clog2(eff_max + 10);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cubic_bezier_spline_generator_core.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_spline_generator_core
// Turns a stream of control points into sampled cubic Bezier curves.
//
//   Channel  Direction  Handshake             Payload
//   in_      slave      in_tvalid/in_tready   tdata: point_x, point_y; tlast: end_of_spline
//   out_     master     out_tvalid/out_tready tdata: curve_x, curve_y; tlast: last_of_curve
//   cfg_     slave      cfg_valid/cfg_ready   data: section_count
//
// A point is taken whenever the job queue has room. A curve passes the back
// end in order: load the job, set up the coefficients, prime the differences,
// then one sample per cycle from the forward-difference accumulators while
// the output is not held. Samples then pass through the rounding pipeline.
// Reset is synchronous and needs no clearing pass.
// Low out_tready while a result is offered holds the back end; points are
// still taken until the two-entry job queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_spline_generator_core #(
  parameter int MAX_SECTIONS = cbsg_pkg::MAX_SECTIONS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // [15:0] point_x, [31:16] point_y
  input  wire logic [cbsg_pkg::TDATA_W-1:0] in_tdata,
  input  wire logic                         in_tlast,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // [15:0] curve_x, [31:16] curve_y
  output logic [cbsg_pkg::TDATA_W-1:0]      out_tdata,
  output logic                              out_tlast,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [cbsg_pkg::SC_W-1:0]    cfg_data
);
  import cbsg_pkg::*;

  logic [SC_W-1:0] sc_r;
  queue_status_t   q_stat;
  job_t            push_job, pop_job;
  logic            push, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r <= SC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sc_r <= cfg_data;
    end
  end

  cbsg_front #(
    .MAX_SECTIONS(MAX_SECTIONS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .sc_cfg    (sc_r),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  cbsg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_stat   (q_stat),
    .pop_job  (pop_job)
  );

  cbsg_back #(
    .MAX_SECTIONS(MAX_SECTIONS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop_job    (pop_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/cbsg_front.sv =====
// ----------------------------------------------------------------------------
// cbsg_front
// Accepts control points, keeps the three previous points and the fill count,
// and pushes a curve job whenever a point completes a curve.
// ----------------------------------------------------------------------------
`default_nettype none

module cbsg_front #(
  parameter int MAX_SECTIONS = cbsg_pkg::MAX_SECTIONS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [cbsg_pkg::TDATA_W-1:0] in_tdata,
  input  wire logic                         in_tlast,
  input  wire logic [cbsg_pkg::SC_W-1:0]    sc_cfg,
  input  wire cbsg_pkg::queue_status_t      q_stat,
  output logic                              push,
  output cbsg_pkg::job_t                    push_job
);
  import cbsg_pkg::*;

  localparam logic [2:0] FILL_FULL  = 3'd4;
  localparam logic [2:0] FILL_AFTER = 3'd2;

  logic [2:0]           fill_r, fill_nxt;
  logic signed [CW-1:0] wx_r [3];
  logic signed [CW-1:0] wy_r [3];
  logic signed [CW-1:0] px, py;
  logic                 accept, emit;
  logic [SC_W-1:0]      sc_clamped;

  assign in_tready = ~q_stat.full;
  assign accept    = in_tvalid & in_tready;
  assign px        = in_tdata[CW-1:0];
  assign py        = in_tdata[2*CW-1:CW];
  assign emit      = (fill_r == FILL_FULL);
  assign push      = accept & emit;

  always_comb begin
    if (MAX_SECTIONS < SC_MAX_CODE && int'(sc_cfg) > MAX_SECTIONS) begin
      sc_clamped = SC_W'(MAX_SECTIONS);
    end else begin
      sc_clamped = sc_cfg;
    end
  end

  always_comb begin
    push_job.ax = wx_r[0];
    push_job.bx = wx_r[1];
    push_job.cx = wx_r[2];
    push_job.dx = px;
    push_job.ay = wy_r[0];
    push_job.by = wy_r[1];
    push_job.cy = wy_r[2];
    push_job.dy = py;
    push_job.sc = sc_clamped;
  end

  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      if (in_tlast) begin
        fill_nxt = '0;
      end else if (emit) begin
        fill_nxt = FILL_AFTER;
      end else begin
        fill_nxt = fill_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Window contents are only read once the fill count says they are valid.
  always_ff @(posedge clk) begin
    if (accept) begin
      wx_r[0] <= wx_r[1];
      wx_r[1] <= wx_r[2];
      wx_r[2] <= px;
      wy_r[0] <= wy_r[1];
      wy_r[1] <= wy_r[2];
      wy_r[2] <= py;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cbsg_queue.sv =====
// ----------------------------------------------------------------------------
// cbsg_queue
// Short queue of curve jobs between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cbsg_queue (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  input  wire cbsg_pkg::job_t          push_job,
  input  wire logic                    pop,
  output cbsg_pkg::queue_status_t      q_stat,
  output cbsg_pkg::job_t               pop_job
);
  import cbsg_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  job_t             mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign q_stat.full  = (cnt_r == CNT_W'(QDEPTH));
  assign q_stat.valid = (cnt_r != '0);
  assign do_push      = push & ~q_stat.full;
  assign do_pop       = pop & q_stat.valid;
  assign pop_job      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cbsg_round.sv =====
// ----------------------------------------------------------------------------
// cbsg_round
// Four-stage pipeline that turns an accumulator value into a coordinate:
// divide by 1000 rounding half up, then saturate to the signed range.
// ----------------------------------------------------------------------------
`default_nettype none

module cbsg_round #(
  parameter int NUM_W = cbsg_pkg::num_width(cbsg_pkg::MAX_SECTIONS_DEF)
) (
  input  wire logic                    clk,
  input  wire logic                    ce,
  input  wire logic signed [NUM_W-1:0] num,
  output logic [cbsg_pkg::CW-1:0]      res
);
  import cbsg_pkg::*;

  localparam logic signed [NUM_W-1:0] HI_C   = NUM_W'(HI_LIM);
  localparam logic signed [NUM_W-1:0] LO_C   = NUM_W'(LO_LIM);
  localparam logic signed [NUM_W-1:0] BIAS_C = NUM_W'(BIAS);
  localparam int PROD_W = U_W + RECIP_W;

  logic signed [NUM_W-1:0] v;
  logic [U_W-1:0]          u1_r, u2_r;
  logic                    hi1_r, lo1_r, hi2_r, lo2_r, hi3_r, lo3_r;
  logic [PROD_W-1:0]       prod2_r;
  logic [CW-1:0]           q_est, q3_r, q4;
  logic [U_W-1:0]          rem_full;
  logic [REM_W-1:0]        rem3_r;
  logic [CW-1:0]           res_r;

  // In range, the biased value is non-negative and below 1000 * 2^CW.
  assign v        = num + BIAS_C;
  assign q_est    = prod2_r[RECIP_SH +: CW];
  assign rem_full = u2_r - U_W'(q_est) * U_W'(DIV_ODD);
  assign q4       = q3_r + CW'(rem3_r >= REM_W'(DIV_ODD));
  assign res      = res_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      hi1_r   <= (num >= HI_C);
      lo1_r   <= (num < LO_C);
      u1_r    <= v[V_W-1:DIV_SHIFT];

      hi2_r   <= hi1_r;
      lo2_r   <= lo1_r;
      u2_r    <= u1_r;
      prod2_r <= PROD_W'(u1_r) * PROD_W'(RECIP);

      hi3_r   <= hi2_r;
      lo3_r   <= lo2_r;
      q3_r    <= q_est;
      rem3_r  <= rem_full[REM_W-1:0];

      // The quotient carries the bias of 2^(CW-1); flipping the top bit removes it.
      if (hi3_r) begin
        res_r <= {1'b0, {(CW-1){1'b1}}};
      end else if (lo3_r) begin
        res_r <= {1'b1, {(CW-1){1'b0}}};
      end else begin
        res_r <= {~q4[CW-1], q4[CW-2:0]};
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cbsg_back.sv =====
// ----------------------------------------------------------------------------
// cbsg_back
// Curve sequencer: takes a job from the queue, derives the cubic coefficients,
// and steps the curve by forward differences, one sample per cycle while the
// output is not held, into the rounding pipelines and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbsg_back #(
  parameter int MAX_SECTIONS = cbsg_pkg::MAX_SECTIONS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cbsg_pkg::queue_status_t       q_stat,
  input  wire cbsg_pkg::job_t                pop_job,
  output logic                               pop,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [cbsg_pkg::TDATA_W-1:0]       out_tdata,
  output logic                               out_tlast
);
  import cbsg_pkg::*;

  localparam int EFF_MAX = (MAX_SECTIONS < SC_MAX_CODE) ? MAX_SECTIONS : SC_MAX_CODE;
  localparam int NUM_W   = num_width(EFF_MAX);
  localparam int N_W     = $clog2(EFF_MAX + 1);

  localparam logic signed [COEF_W-1:0] C3    = COEF_W'(3);
  localparam logic signed [COEF_W-1:0] C6    = COEF_W'(6);
  localparam logic signed [NUM_W-1:0]  K6    = NUM_W'(6);
  localparam logic signed [NUM_W-1:0]  K10   = NUM_W'(10);
  localparam logic signed [NUM_W-1:0]  K20   = NUM_W'(20);
  localparam logic signed [NUM_W-1:0]  K100  = NUM_W'(100);
  localparam logic signed [NUM_W-1:0]  K1000 = NUM_W'(1000);

  seq_state_t state_r, state_nxt;
  job_t       job_r;
  logic [N_W-1:0] n_r;

  logic signed [CW-1:0]     pa [2];
  logic signed [CW-1:0]     pb [2];
  logic signed [CW-1:0]     pc [2];
  logic signed [CW-1:0]     pd [2];
  logic signed [COEF_W-1:0] ca_r [2];
  logic signed [COEF_W-1:0] cb_r [2];
  logic signed [COEF_W-1:0] cc_r [2];
  logic signed [NUM_W-1:0]  num_r [2];
  logic signed [NUM_W-1:0]  d1_r [2];
  logic signed [NUM_W-1:0]  d2_r [2];
  logic signed [NUM_W-1:0]  d3_r [2];
  logic [CW-1:0]            res [2];

  logic [RND_LAT-1:0] vpipe_r;
  logic [RND_LAT-1:0] lpipe_r;
  logic               ce, issue, last_smp;

  // The sample steps and the rounding pipelines advance together; a held result freezes them.
  assign ce       = ~vpipe_r[RND_LAT-1] | out_tready;
  assign last_smp = (SC_W'(n_r) == job_r.sc);
  assign issue    = (state_r == ST_RUN) & ce;
  assign pop      = (state_r == ST_IDLE) & q_stat.valid;

  assign pa[0] = job_r.ax;
  assign pb[0] = job_r.bx;
  assign pc[0] = job_r.cx;
  assign pd[0] = job_r.dx;
  assign pa[1] = job_r.ay;
  assign pb[1] = job_r.by;
  assign pc[1] = job_r.cy;
  assign pd[1] = job_r.dy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_stat.valid) begin
          state_nxt = ST_COEF;
        end
      end
      ST_COEF:  state_nxt = ST_PRIME;
      ST_PRIME: state_nxt = ST_RUN;
      ST_RUN: begin
        if (ce && last_smp) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vpipe_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (ce) begin
        vpipe_r <= {vpipe_r[RND_LAT-2:0], issue};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= pop_job;
    end
    if (ce) begin
      lpipe_r <= {lpipe_r[RND_LAT-2:0], last_smp};
    end
    for (int k = 0; k < 2; k++) begin
      if (state_r == ST_COEF) begin
        ca_r[k] <= COEF_W'(pd[k]) - COEF_W'(pa[k]) + C3 * (COEF_W'(pb[k]) - COEF_W'(pc[k]));
        cb_r[k] <= C3 * (COEF_W'(pa[k]) + COEF_W'(pc[k])) - C6 * COEF_W'(pb[k]);
        cc_r[k] <= C3 * (COEF_W'(pb[k]) - COEF_W'(pa[k]));
      end
      // Differences of A*n^3 + 10*B*n^2 + 100*C*n + 1000*a at n = 0.
      if (state_r == ST_PRIME) begin
        num_r[k] <= K1000 * NUM_W'(pa[k]);
        d1_r[k]  <= NUM_W'(ca_r[k]) + K10 * NUM_W'(cb_r[k]) + K100 * NUM_W'(cc_r[k]);
        d2_r[k]  <= K6 * NUM_W'(ca_r[k]) + K20 * NUM_W'(cb_r[k]);
        d3_r[k]  <= K6 * NUM_W'(ca_r[k]);
      end else if (issue) begin
        num_r[k] <= num_r[k] + d1_r[k];
        d1_r[k]  <= d1_r[k] + d2_r[k];
        d2_r[k]  <= d2_r[k] + d3_r[k];
      end
    end
    if (state_r == ST_PRIME) begin
      n_r <= '0;
    end else if (issue) begin
      n_r <= n_r + N_W'(1);
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_rnd
    cbsg_round #(
      .NUM_W(NUM_W)
    ) u_round (
      .clk (clk),
      .ce  (ce),
      .num (num_r[g]),
      .res (res[g])
    );
  end

  assign out_tvalid = vpipe_r[RND_LAT-1];
  assign out_tlast  = lpipe_r[RND_LAT-1];
  assign out_tdata  = TDATA_W'({res[1], res[0]});

endmodule

`default_nettype wire

// ===== hw/rtl/cbsg_checker.sv =====
// ----------------------------------------------------------------------------
// cbsg_checker
// Port-level checks of the spline generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cbsg_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_tready,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [cbsg_pkg::TDATA_W-1:0] out_tdata,
  input wire logic                         out_tlast
);
  import cbsg_pkg::*;

  // A held result stays offered until the transaction completes.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // No result just after reset: no curve can come out before five points go in.
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid ##1 !out_tvalid ##1 !out_tvalid)
    else $error("result shortly after reset");

  // The job queue is empty after reset, so points are taken at once.
  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind cubic_bezier_spline_generator_core cbsg_checker u_cbsg_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cubic Bezier spline generator core. Control
// points are streamed in with random gaps while the result side stalls at
// random. Each accepted point updates a local model of the point window,
// which queues the curve samples it should produce. Every result
// transaction is checked against the oldest queued sample. A short directed
// table runs first, followed by random splines over several section counts.
// ----------------------------------------------------------------------------

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbsg_pkg::*;

  localparam int MAX_SECT     = cbsg_pkg::MAX_SECTIONS_DEF;
  localparam int SETTLE_CYC   = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RAND_POINTS  = 87;
  localparam int PHASE_POINTS = 22;
  localparam int N_ROWS       = 23;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last;
  } curve_sample_t;

  // One directed step: optional section count write, then one point. Rows
  // with a known answer give the single value every sample must take.
  typedef struct packed {
    logic                 cfg_en;
    logic [SC_W-1:0]      cfg_val;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic                 eos;
    logic                 known;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
  } stim_row_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata   = '0;
  logic               in_tlast   = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tlast;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [SC_W-1:0]    cfg_data   = '0;

  // Model of the point window and the section count register.
  logic signed [CW-1:0] pts_x [4];
  logic signed [CW-1:0] pts_y [4];
  logic [2:0]           pts_seen;
  logic [SC_W-1:0]      sections;

  curve_sample_t curve_q [$];
  int            errors = 0;
  int            cycles = 0;
  int            stall_left = 0;
  logic          steady = 1'b0;

  stim_row_t dir_rows [N_ROWS] = '{
    // Point 0 is never a curve start; points 1 to 4 are equal, so the curve
    // is flat at that point.
    '{1'b0, 4'd0, -32768, -32768, 1'b0, 1'b0, 0, 0},
    '{1'b0, 4'd0,  32767, -32768, 1'b0, 1'b0, 0, 0},
    '{1'b0, 4'd0,  32767, -32768, 1'b0, 1'b0, 0, 0},
    '{1'b0, 4'd0,  32767, -32768, 1'b0, 1'b0, 0, 0},
    '{1'b0, 4'd0,  32767, -32768, 1'b0, 1'b1, 32767, -32768},
    '{1'b0, 4'd0,      0,      0, 1'b0, 1'b0, 0, 0},
    '{1'b0, 4'd0,  32767,  32767, 1'b0, 1'b0, 0, 0},
    // Curve on the last point of the spline, then the window clears.
    '{1'b0, 4'd0, -32768, -32768, 1'b1, 1'b0, 0, 0},
    // Last point right after a clear: no curve.
    '{1'b0, 4'd0,   4660,  17185, 1'b1, 1'b0, 0, 0},
    // No sections: the only sample is the first control point.
    '{1'b1, 4'd0,  21845, -21846, 1'b0, 1'b0, 0, 0},
    '{1'b0, 4'd0,   1234,  -1234, 1'b0, 1'b0, 0, 0},
    '{1'b0, 4'd0, -32768,  32767, 1'b0, 1'b0, 0, 0},
    '{1'b0, 4'd0,  32767, -32768, 1'b0, 1'b0, 0, 0},
    '{1'b0, 4'd0,      0,      0, 1'b1, 1'b1, 1234, -1234},
    // Fifteen sections run past t = 1 and saturate.
    '{1'b1, 4'd15,     0,      0, 1'b0, 1'b0, 0, 0},
    '{1'b0, 4'd0, -32768, -32768, 1'b0, 1'b0, 0, 0},
    '{1'b0, 4'd0,  32767,  32767, 1'b0, 1'b0, 0, 0},
    '{1'b0, 4'd0,  32767,  32767, 1'b0, 1'b0, 0, 0},
    '{1'b0, 4'd0, -32768, -32768, 1'b0, 1'b0, 0, 0},
    '{1'b0, 4'd0,    100,   -100, 1'b0, 1'b0, 0, 0},
    '{1'b0, 4'd0,  -2000,   3000, 1'b0, 1'b0, 0, 0},
    '{1'b0, 4'd0,   4096,  -4096, 1'b0, 1'b0, 0, 0},
    '{1'b0, 4'd0,     -1,     -1, 1'b1, 1'b0, 0, 0}
  };

  cubic_bezier_spline_generator_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample n of the cubic at t = n/10, rounded half up and saturated.
  function automatic logic signed [CW-1:0] bezier_sample(input longint a, input longint b,
                                                         input longint c, input longint d,
                                                         input longint n);
    longint ca, cb, cc, num, q, hi, lo;
    ca  = -a + 3 * b - 3 * c + d;
    cb  = 3 * a - 6 * b + 3 * c;
    cc  = 3 * b - 3 * a;
    num = ca * n * n * n + cb * n * n * 10 + cc * n * 100 + a * 1000 + 500;
    q   = num / 1000;
    if ((num % 1000) != 0 && num < 0) q = q - 1;
    hi = (longint'(1) << (CW - 1)) - 1;
    lo = -(longint'(1) << (CW - 1));
    if (q > hi) q = hi;
    if (q < lo) q = lo;
    return q[CW-1:0];
  endfunction

  function automatic void reset_window();
    for (int m = 0; m < 4; m++) begin
      pts_x[m] = '0;
      pts_y[m] = '0;
    end
    pts_seen = '0;
  endfunction

  // Moves one accepted point through the window and queues its curve.
  function automatic int advance_window(input logic signed [CW-1:0] x,
                                        input logic signed [CW-1:0] y, input logic eos);
    curve_sample_t s;
    int            produced;
    int            sc;
    produced = 0;
    sc = (sections > MAX_SECT) ? MAX_SECT : int'(sections);
    pts_x[3] = x;
    pts_y[3] = y;
    if (pts_seen > 3) begin
      for (int n = 0; n <= sc; n++) begin
        s.x    = bezier_sample(pts_x[0], pts_x[1], pts_x[2], pts_x[3], n);
        s.y    = bezier_sample(pts_y[0], pts_y[1], pts_y[2], pts_y[3], n);
        s.last = (n == sc);
        curve_q.insert(curve_q.size(), s);
        produced++;
      end
      pts_seen = 3'd1;
    end
    for (int m = 0; m < 3; m++) begin
      pts_x[m] = pts_x[m+1];
      pts_y[m] = pts_y[m+1];
    end
    pts_seen = pts_seen + 3'd1;
    if (eos) reset_window();
    return produced;
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2, 3, 4: return CW'($urandom_range(0, 2047)) - CW'(1024);
      default: return CW'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with in_tvalid still high, so the next point can follow back to back.
  task automatic send_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                            input logic eos, output int produced);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    produced = advance_window(x, y, eos);
    @(negedge clk);
  endtask

  // Writes the section count once the core has drained.
  task automatic write_sections(input logic [SC_W-1:0] v);
    in_tvalid <= 1'b0;
    while (curve_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sections = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (steady) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 75) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin : result_check
    curve_sample_t want;
    logic signed [CW-1:0] got_x, got_y;
    got_x = out_tdata[CW-1:0];
    got_y = out_tdata[2*CW-1:CW];
    if (rst_n && out_tvalid && out_tready) begin
      if (curve_q.size() == 0) begin
        $display("%0t: unexpected sample x %0d y %0d last %0b", $time, got_x, got_y,
                 out_tlast);
        errors++;
      end else begin
        want = curve_q.pop_front();
        if (got_x !== want.x) begin
          $display("%0t: curve_x expected %0d got %0d", $time, want.x, got_x);
          errors++;
        end
        if (got_y !== want.y) begin
          $display("%0t: curve_y expected %0d got %0d", $time, want.y, got_y);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last_of_curve expected %0b got %0b", $time, want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int        produced;
    int        sent;
    int        phase;
    int        in_phase;
    int        len;
    stim_row_t row;

    reset_window();
    sections = cbsg_pkg::SC_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      row = dir_rows[i];
      if (row.cfg_en) write_sections(row.cfg_val);
      send_point(row.px, row.py, row.eos, produced);
      if (row.known) begin
        for (int j = curve_q.size() - produced; j < curve_q.size(); j++) begin
          curve_q[j].x = row.ex;
          curve_q[j].y = row.ey;
        end
      end
    end

    // Random splines: mostly lengths that close a whole number of curves,
    // some short or odd ones that stop mid-window.
    sent  = 0;
    phase = 0;
    while (sent < RAND_POINTS) begin
      steady = 1'b0;
      case (phase)
        0:       write_sections(4'd0);
        1:       write_sections(4'd15);
        default: write_sections(SC_W'($urandom_range(0, 15)));
      endcase
      steady   = (phase == 2);
      in_phase = 0;
      while (in_phase < PHASE_POINTS && sent < RAND_POINTS) begin
        if ($urandom_range(0, 4) == 0) len = $urandom_range(1, 12);
        else len = 2 + 3 * $urandom_range(1, 4);
        for (int k = 0; k < len && sent < RAND_POINTS; k++) begin
          send_point(rand_coord(), rand_coord(), k == len - 1, produced);
          sent++;
          in_phase++;
        end
      end
      phase++;
    end

    in_tvalid <= 1'b0;
    steady = 1'b0;
    while (curve_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    if (errors == 0 && curve_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cbsg_pkg.sv
hw/rtl/cbsg_front.sv
hw/rtl/cbsg_queue.sv
hw/rtl/cbsg_round.sv
hw/rtl/cbsg_back.sv
hw/rtl/cubic_bezier_spline_generator_core.sv
hw/rtl/cbsg_checker.sv
bench/tb.sv
